>>> rtl/xsms_pkg.sv
// xsms_pkg: shared constants, codes and payload types of the xy scan motion sequencer
// no dependencies; imported by the top level and the motion unit of the block

package xsms_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RW_W        = (CNT_W > 8) ? CNT_W : 8;

  // 0.01 and 1.0e-5 in the fixed point format, rounded and saturated
  localparam int MS_RAW   = ((1 << FRAC_BITS) + 50) / 100;
  localparam int MS_RESET = (MS_RAW < 1) ? 1 : ((MS_RAW > 65535) ? 65535 : MS_RAW);
  localparam int SM_RAW   = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam int SM_RESET = (SM_RAW > 255) ? 255 : SM_RAW;

  typedef enum logic [3:0] {
    MODE_TICK    = 4'd0,
    MODE_SET     = 4'd1,
    MODE_CONFIG  = 4'd2,
    MODE_APPEND  = 4'd3,
    MODE_RUN     = 4'd4,
    MODE_PAUSE   = 4'd5,
    MODE_RESUME  = 4'd6,
    MODE_STOP    = 4'd7,
    MODE_REWIND  = 4'd8,
    MODE_ABORT   = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_WRONG  = 3'd1,
    STAT_NEGRW  = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CTL_IDLE    = 2'd0,
    CTL_READY   = 2'd1,
    CTL_RUNNING = 2'd2,
    CTL_PAUSED  = 2'd3
  } ctl_t;

  typedef enum logic {
    REG_MAX_STEP    = 1'b0,
    REG_SNAP_MARGIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [7:0]  rewind_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         scan_state;
    logic signed [31:0] setpoint_x;
    logic signed [31:0] setpoint_y;
    logic signed [31:0] readback_x;
    logic signed [31:0] readback_y;
    logic               setpoint_changed;
    logic               readback_changed;
    logic               state_changed;
    logic               scan_complete;
  } out_item_t;

  typedef struct packed {
    logic [31:0] tgt_x;
    logic [31:0] tgt_y;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } mot_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] new_x;
    logic [31:0] new_y;
  } mot_rsp_t;

endpackage

>>> rtl/xy_scan_motion_sequencer_top.sv
// Two-axis scan sequencer. One transaction in gives exactly one result transaction out.
// A command result is formed in T_EXEC and registered in T_OUT; a rewind also reads the
// point table in T_RD and T_LOAD. A tick that moves nothing passes through T_POST. A tick
// that moves the readback runs the bit-serial motion unit: two squares, then a square of
// the snap distance when the move is short; a move that does not snap then takes a square
// root and one multiply/divide pass per axis. Loading the next table point adds the T_RD
// and T_LOAD states. The point table is a 64 x 64 ram. One item is handled at a time,
// and the next is taken while the previous result waits at the output.
// depends on xsms_pkg, xsms_ram, xsms_motion

module xy_scan_motion_sequencer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  xsms_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output xsms_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import xsms_pkg::*;

  typedef enum logic [2:0] {
    T_IN, T_EXEC, T_MOT, T_POST, T_RD, T_LOAD, T_OUT
  } tstate_t;

  tstate_t           state_r;
  in_item_t          in_r;
  ctl_t              ctl_r;
  logic [31:0]       tgt_x_r, tgt_y_r, pos_x_r, pos_y_r;
  logic [CNT_W-1:0]  cnt_r, sidx_r;
  logic [IDX_W-1:0]  rd_addr_r;
  status_t           status_r;
  logic              sp_chg_r, rb_chg_r, st_chg_r, done_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic [15:0]       max_step_r;
  logic [7:0]        snap_margin_r;

  logic              ram_we;
  logic [63:0]       ram_rdata;
  logic              mot_start;
  mot_req_t          mot_req;
  mot_rsp_t          mot_rsp;
  logic              moving;
  logic              at_target;
  logic [RW_W-1:0]   rcw, siw, rw_idx;
  logic [CNT_W-1:0]  sidx_inc;

  always_comb begin
    moving    = ((ctl_r == CTL_IDLE) || (ctl_r == CTL_RUNNING)) &&
                ((pos_x_r != tgt_x_r) || (pos_y_r != tgt_y_r));
    at_target = (pos_x_r == tgt_x_r) && (pos_y_r == tgt_y_r);
    mot_start = (state_r == T_EXEC) && (in_r.mode == MODE_TICK) && moving;
    ram_we    = (state_r == T_EXEC) && (in_r.mode == MODE_APPEND) &&
                (ctl_r == CTL_READY) && (cnt_r < CNT_W'(TABLE_DEPTH));
    mot_req   = '{tgt_x: tgt_x_r, tgt_y: tgt_y_r, pos_x: pos_x_r, pos_y: pos_y_r};
    rcw       = RW_W'(in_r.rewind_count[6:0]);
    siw       = RW_W'(sidx_r);
    rw_idx    = (rcw < siw) ? (siw - rcw - RW_W'(1)) : '0;
    if (rw_idx >= RW_W'(cnt_r)) begin
      rw_idx = '0;
    end
    sidx_inc  = CNT_W'(rd_addr_r) + CNT_W'(1);
  end

  xsms_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({in_r.coord_x, in_r.coord_y}),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  xsms_motion u_motion (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (mot_start),
    .req         (mot_req),
    .max_step    (max_step_r),
    .snap_margin (snap_margin_r),
    .rsp         (mot_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IN;
      ctl_r         <= CTL_IDLE;
      tgt_x_r       <= 32'd0;
      tgt_y_r       <= 32'd0;
      pos_x_r       <= 32'd0;
      pos_y_r       <= 32'd0;
      cnt_r         <= '0;
      sidx_r        <= '0;
      out_valid_r   <= 1'b0;
      max_step_r    <= 16'(MS_RESET);
      snap_margin_r <= 8'(SM_RESET);
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_MAX_STEP:    max_step_r    <= cfg_wdata;
          REG_SNAP_MARGIN: snap_margin_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        T_IN: begin
          if (in_valid) begin
            in_r     <= in_data;
            status_r <= STAT_OK;
            sp_chg_r <= 1'b0;
            rb_chg_r <= 1'b0;
            st_chg_r <= 1'b0;
            done_r   <= 1'b0;
            state_r  <= T_EXEC;
          end
        end
        T_EXEC: begin
          state_r <= T_OUT;
          unique case (in_r.mode)
            MODE_TICK: state_r <= moving ? T_MOT : T_POST;
            MODE_SET: begin
              if (ctl_r != CTL_IDLE) begin
                status_r <= STAT_WRONG;
              end else begin
                tgt_x_r  <= in_r.coord_x;
                tgt_y_r  <= in_r.coord_y;
                sp_chg_r <= 1'b1;
              end
            end
            MODE_CONFIG, MODE_STOP, MODE_ABORT: begin
              if ((in_r.mode == MODE_CONFIG && ctl_r != CTL_IDLE) ||
                  (in_r.mode == MODE_STOP && ctl_r == CTL_IDLE)) begin
                status_r <= STAT_WRONG;
              end else begin
                ctl_r    <= (in_r.mode == MODE_ABORT) ? CTL_IDLE : CTL_READY;
                st_chg_r <= 1'b1;
                if (in_r.mode != MODE_STOP) begin
                  cnt_r <= '0;
                end
                if (!at_target) begin
                  tgt_x_r  <= pos_x_r;
                  tgt_y_r  <= pos_y_r;
                  sp_chg_r <= 1'b1;
                end
              end
            end
            MODE_APPEND: begin
              if (ctl_r != CTL_READY) begin
                status_r <= STAT_WRONG;
              end else if (!ram_we) begin
                status_r <= STAT_FULL;
              end else begin
                cnt_r <= cnt_r + CNT_W'(1);
              end
            end
            MODE_RUN: begin
              if (ctl_r != CTL_READY) begin
                status_r <= STAT_WRONG;
              end else begin
                sidx_r   <= '0;
                ctl_r    <= CTL_RUNNING;
                st_chg_r <= 1'b1;
              end
            end
            MODE_PAUSE: begin
              if (ctl_r != CTL_RUNNING) begin
                status_r <= STAT_WRONG;
              end else begin
                ctl_r    <= CTL_PAUSED;
                st_chg_r <= 1'b1;
              end
            end
            MODE_RESUME: begin
              if (ctl_r != CTL_PAUSED) begin
                status_r <= STAT_WRONG;
              end else begin
                ctl_r    <= CTL_RUNNING;
                st_chg_r <= 1'b1;
              end
            end
            MODE_REWIND: begin
              if (ctl_r != CTL_RUNNING && ctl_r != CTL_PAUSED) begin
                status_r <= STAT_WRONG;
              end else if (in_r.rewind_count[7]) begin
                status_r <= STAT_NEGRW;
              end else if (in_r.rewind_count == 8'sd0) begin
                status_r <= STAT_OK;
              end else if (cnt_r == '0) begin
                status_r <= STAT_EMPTY;
              end else begin
                rd_addr_r <= rw_idx[IDX_W-1:0];
                state_r   <= T_RD;
              end
            end
            default: ;
          endcase
        end
        T_MOT: begin
          if (mot_rsp.done) begin
            pos_x_r  <= mot_rsp.new_x;
            pos_y_r  <= mot_rsp.new_y;
            rb_chg_r <= 1'b1;
            state_r  <= T_POST;
          end
        end
        T_POST: begin
          state_r <= T_OUT;
          if (ctl_r == CTL_RUNNING && at_target) begin
            if (sidx_r < cnt_r) begin
              rd_addr_r <= sidx_r[IDX_W-1:0];
              state_r   <= T_RD;
            end else begin
              // table exhausted: scan ends back in ready
              done_r   <= 1'b1;
              ctl_r    <= CTL_READY;
              st_chg_r <= 1'b1;
            end
          end
        end
        T_RD: state_r <= T_LOAD;
        T_LOAD: begin
          tgt_x_r  <= ram_rdata[63:32];
          tgt_y_r  <= ram_rdata[31:0];
          sidx_r   <= sidx_inc;
          sp_chg_r <= 1'b1;
          state_r  <= T_OUT;
        end
        T_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.status           <= status_r;
            out_r.scan_state       <= ctl_r;
            out_r.setpoint_x       <= tgt_x_r;
            out_r.setpoint_y       <= tgt_y_r;
            out_r.readback_x       <= pos_x_r;
            out_r.readback_y       <= pos_y_r;
            out_r.setpoint_changed <= sp_chg_r;
            out_r.readback_changed <= rb_chg_r;
            out_r.state_changed    <= st_chg_r;
            out_r.scan_complete    <= done_r;
            out_valid_r            <= 1'b1;
            state_r                <= T_IN;
          end
        end
        default: state_r <= T_IN;
      endcase
    end
  end

  assign in_ready  = (state_r == T_IN);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  property p_one_at_a_time;
    @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready;
  endproperty
  a_one_at_a_time: assert property (p_one_at_a_time) else $error("second transaction taken");

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(TABLE_DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("point count over depth");

  property p_done_in_wait;
    @(posedge clk) disable iff (!rst_n) mot_rsp.done |-> state_r == T_MOT;
  endproperty
  a_done_in_wait: assert property (p_done_in_wait) else $error("motion done outside wait");

  property p_complete_ready;
    @(posedge clk) disable iff (!rst_n)
      (state_r == T_OUT && done_r) |-> ctl_r == CTL_READY;
  endproperty
  a_complete_ready: assert property (p_complete_ready) else $error("complete not in ready");

endmodule

>>> rtl/xsms_ram.sv
// xsms_ram: generic single write, single read ram with registered read data
// no dependencies

module xsms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/xsms_motion.sv
// xsms_motion: one readback move per request, bit-serial squares, square root and divide
// depends on xsms_pkg

module xsms_motion (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  xsms_pkg::mot_req_t  req,
  input  logic [15:0]         max_step,
  input  logic [7:0]          snap_margin,
  output xsms_pkg::mot_rsp_t  rsp
);
  import xsms_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_PREP, M_SQX, M_SQY, M_MSQ, M_SQRT, M_MUL, M_DIV, M_DONE
  } mstate_t;

  mstate_t      state_r;
  mot_req_t     req_r;
  logic [31:0]  rx_r, ry_r, r_r;
  logic         sx_r, sy_r, near_r, axis_r;
  logic [63:0]  acc_r, mcand_r, s_r, v_r, rt_r, bit_r;
  logic [31:0]  mplier_r;
  logic [5:0]   cnt_r;
  logic [49:0]  rem_r, dsh_r;
  logic [15:0]  q_r;
  logic [31:0]  new_x_r, new_y_r;
  logic         done_r;

  logic [32:0]  dx, dy;
  logic [31:0]  ax, ay;
  logic         sh;
  logic [16:0]  m;
  logic [63:0]  acc_add, trial;
  logic         sq_ge, div_ge;
  logic [15:0]  q_nxt;
  logic [31:0]  p_sel, stepped;

  always_comb begin
    dx      = {req_r.tgt_x[31], req_r.tgt_x} - {req_r.pos_x[31], req_r.pos_x};
    dy      = {req_r.tgt_y[31], req_r.tgt_y} - {req_r.pos_y[31], req_r.pos_y};
    ax      = dx[32] ? 32'(-dx) : dx[31:0];
    ay      = dy[32] ? 32'(-dy) : dy[31:0];
    sh      = ax[31] | ay[31];
    m       = 17'(max_step) + 17'(snap_margin);
    acc_add = acc_r + (mplier_r[0] ? mcand_r : 64'd0);
    trial   = rt_r + bit_r;
    sq_ge   = v_r >= trial;
    div_ge  = rem_r >= dsh_r;
    q_nxt   = {q_r[14:0], div_ge};
    p_sel   = axis_r ? req_r.pos_y : req_r.pos_x;
    // move toward the setpoint on this axis
    if (axis_r ? sy_r : sx_r) begin
      stepped = p_sel - {16'd0, q_nxt};
    end else begin
      stepped = p_sel + {16'd0, q_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            req_r   <= req;
            state_r <= M_PREP;
          end
        end
        M_PREP: begin
          rx_r     <= sh ? {1'b0, ax[31:1]} : ax;
          ry_r     <= sh ? {1'b0, ay[31:1]} : ay;
          sx_r     <= dx[32];
          sy_r     <= dy[32];
          near_r   <= (ax <= {15'd0, m}) && (ay <= {15'd0, m});
          acc_r    <= 64'd0;
          mcand_r  <= {32'd0, (sh ? {1'b0, ax[31:1]} : ax)};
          mplier_r <= sh ? {1'b0, ax[31:1]} : ax;
          cnt_r    <= 6'd32;
          state_r  <= M_SQX;
        end
        M_SQX, M_SQY, M_MSQ, M_MUL: begin
          acc_r    <= acc_add;
          mcand_r  <= {mcand_r[62:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[31:1]};
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            priority case (state_r)
              M_SQX: begin
                mcand_r  <= {32'd0, ry_r};
                mplier_r <= ry_r;
                cnt_r    <= 6'd32;
                state_r  <= M_SQY;
              end
              M_SQY: begin
                s_r <= acc_add;
                if (near_r) begin
                  acc_r    <= 64'd0;
                  mcand_r  <= {47'd0, m};
                  mplier_r <= {15'd0, m};
                  cnt_r    <= 6'd17;
                  state_r  <= M_MSQ;
                end else begin
                  v_r     <= acc_add;
                  rt_r    <= 64'd0;
                  bit_r   <= 64'h4000_0000_0000_0000;
                  cnt_r   <= 6'd32;
                  state_r <= M_SQRT;
                end
              end
              M_MSQ: begin
                if (s_r <= acc_add) begin
                  new_x_r <= req_r.tgt_x;
                  new_y_r <= req_r.tgt_y;
                  state_r <= M_DONE;
                end else begin
                  v_r     <= s_r;
                  rt_r    <= 64'd0;
                  bit_r   <= 64'h4000_0000_0000_0000;
                  cnt_r   <= 6'd32;
                  state_r <= M_SQRT;
                end
              end
              default: begin
                // numerator 2*rd*max_step + r, divisor 2r aligned to quotient bit 15
                rem_r   <= {acc_add[48:0], 1'b0} + {18'd0, r_r};
                dsh_r   <= {2'd0, r_r, 16'd0};
                q_r     <= 16'd0;
                cnt_r   <= 6'd16;
                state_r <= M_DIV;
              end
            endcase
          end
        end
        M_SQRT: begin
          if (sq_ge) begin
            v_r  <= v_r - trial;
            rt_r <= {1'b0, rt_r[63:1]} + bit_r;
          end else begin
            rt_r <= {1'b0, rt_r[63:1]};
          end
          bit_r <= {2'b0, bit_r[63:2]};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            if (sq_ge) begin
              r_r <= 32'({1'b0, rt_r[63:1]} + bit_r);
            end else if (rt_r[32:1] == 32'd0) begin
              r_r <= 32'd1;
            end else begin
              r_r <= rt_r[32:1];
            end
            axis_r   <= 1'b0;
            acc_r    <= 64'd0;
            mcand_r  <= {32'd0, rx_r};
            mplier_r <= {16'd0, max_step};
            cnt_r    <= 6'd16;
            state_r  <= M_MUL;
          end
        end
        M_DIV: begin
          if (div_ge) begin
            rem_r <= rem_r - dsh_r;
          end
          dsh_r <= {1'b0, dsh_r[49:1]};
          q_r   <= q_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            if (axis_r) begin
              new_y_r <= stepped;
              state_r <= M_DONE;
            end else begin
              new_x_r  <= stepped;
              axis_r   <= 1'b1;
              acc_r    <= 64'd0;
              mcand_r  <= {32'd0, ry_r};
              mplier_r <= {16'd0, max_step};
              cnt_r    <= 6'd16;
              state_r  <= M_MUL;
            end
          end
        end
        M_DONE: begin
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign rsp = '{done: done_r, new_x: new_x_r, new_y: new_y_r};

  property p_start_idle;
    @(posedge clk) disable iff (!rst_n) start |-> state_r == M_IDLE;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("motion start while busy");

  property p_done_once;
    @(posedge clk) disable iff (!rst_n) rsp.done |=> !rsp.done;
  endproperty
  a_done_once: assert property (p_done_once) else $error("motion done held");

  property p_sqrt_count;
    @(posedge clk) disable iff (!rst_n) state_r == M_SQRT |-> cnt_r != 6'd0;
  endproperty
  a_sqrt_count: assert property (p_sqrt_count) else $error("sqrt counter underflow");

endmodule

>>> bench/xsms_scoreboard.sv
// xsms_scoreboard: predicts every result of the xy scan motion sequencer and checks it
// depends on xsms_pkg; watches the input, result and register write ports of the block
`timescale 1ns / 1ps

module xsms_scoreboard (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  xsms_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  xsms_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata,
  output int                   mismatches,
  output int                   pending,
  output int                   scans_done
);
  import xsms_pkg::*;

  logic [15:0] max_step;
  logic [7:0]  snap_margin;
  ctl_t        phase;
  logic [31:0] sp_x, sp_y, rb_x, rb_y;
  logic [31:0] pts_x [TABLE_DEPTH];
  logic [31:0] pts_y [TABLE_DEPTH];
  int unsigned npts, cursor;
  out_item_t   awaited_results[$];

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] advance(logic [31:0] p, longint d, logic [63:0] rd,
                                          logic [63:0] r);
    logic [63:0] stp;
    longint np;
    stp = (rd * 64'(max_step) * 2 + r) / (2 * r);
    np = longint'($signed(p)) + (d < 0 ? -longint'(stp) : longint'(stp));
    return np[31:0];
  endfunction

  // setpoint falls back onto the readback, true when it actually moved
  function automatic bit park_setpoint();
    if (sp_x != rb_x || sp_y != rb_y) begin
      sp_x = rb_x;
      sp_y = rb_y;
      return 1;
    end
    return 0;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t o;
    longint dx, dy;
    logic [63:0] ax, ay, m, rx, ry, r;
    logic [2:0] st;
    bit spc, rbc, stc, fin;
    st = STAT_OK;
    spc = 0; rbc = 0; stc = 0; fin = 0;
    case (it.mode)
      MODE_TICK: begin
        if ((phase == CTL_IDLE || phase == CTL_RUNNING) && (rb_x != sp_x || rb_y != sp_y)) begin
          dx = longint'($signed(sp_x)) - longint'($signed(rb_x));
          dy = longint'($signed(sp_y)) - longint'($signed(rb_y));
          ax = dx < 0 ? -dx : dx;
          ay = dy < 0 ? -dy : dy;
          m = 64'(max_step) + 64'(snap_margin);
          if (ax > m || ay > m || ax * ax + ay * ay > m * m) begin
            // very long moves are halved so the squares stay in range
            if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
              rx = ax >> 1;
              ry = ay >> 1;
            end else begin
              rx = ax;
              ry = ay;
            end
            r = root64(rx * rx + ry * ry);
            if (r == 0) r = 1;
            rb_x = advance(rb_x, dx, rx, r);
            rb_y = advance(rb_y, dy, ry, r);
          end else begin
            rb_x = sp_x;
            rb_y = sp_y;
          end
          rbc = 1;
        end
        if (phase == CTL_RUNNING && rb_x == sp_x && rb_y == sp_y) begin
          if (cursor < npts) begin
            sp_x = pts_x[cursor];
            sp_y = pts_y[cursor];
            cursor++;
            spc = 1;
          end else begin
            fin = 1;
            phase = CTL_READY;
            stc = 1;
            if (park_setpoint()) spc = 1;
          end
        end
      end
      MODE_SET: begin
        if (phase != CTL_IDLE) st = STAT_WRONG;
        else begin
          sp_x = it.coord_x;
          sp_y = it.coord_y;
          spc = 1;
        end
      end
      MODE_CONFIG: begin
        if (phase != CTL_IDLE) st = STAT_WRONG;
        else begin
          phase = CTL_READY;
          stc = 1;
          npts = 0;
          spc = park_setpoint();
        end
      end
      MODE_APPEND: begin
        if (phase != CTL_READY) st = STAT_WRONG;
        else if (npts >= TABLE_DEPTH) st = STAT_FULL;
        else begin
          pts_x[npts] = it.coord_x;
          pts_y[npts] = it.coord_y;
          npts++;
        end
      end
      MODE_RUN: begin
        if (phase != CTL_READY) st = STAT_WRONG;
        else begin
          cursor = 0;
          phase = CTL_RUNNING;
          stc = 1;
        end
      end
      MODE_PAUSE: begin
        if (phase != CTL_RUNNING) st = STAT_WRONG;
        else begin
          phase = CTL_PAUSED;
          stc = 1;
        end
      end
      MODE_RESUME: begin
        if (phase != CTL_PAUSED) st = STAT_WRONG;
        else begin
          phase = CTL_RUNNING;
          stc = 1;
        end
      end
      MODE_STOP: begin
        if (phase == CTL_IDLE) st = STAT_WRONG;
        else begin
          phase = CTL_READY;
          stc = 1;
          spc = park_setpoint();
        end
      end
      MODE_REWIND: begin
        if (phase != CTL_RUNNING && phase != CTL_PAUSED) st = STAT_WRONG;
        else if (it.rewind_count[7]) st = STAT_NEGRW;
        else if (it.rewind_count == 0) st = STAT_OK;
        else if (npts == 0) st = STAT_EMPTY;
        else begin
          if (int'(it.rewind_count) < cursor) cursor = cursor - int'(it.rewind_count) - 1;
          else cursor = 0;
          if (cursor >= npts) cursor = 0;
          sp_x = pts_x[cursor];
          sp_y = pts_y[cursor];
          cursor++;
          spc = 1;
        end
      end
      MODE_ABORT: begin
        phase = CTL_IDLE;
        stc = 1;
        npts = 0;
        spc = park_setpoint();
      end
      default: ;
    endcase
    o.status = st;
    o.scan_state = phase;
    o.setpoint_x = sp_x;
    o.setpoint_y = sp_y;
    o.readback_x = rb_x;
    o.readback_y = rb_y;
    o.setpoint_changed = spc;
    o.readback_changed = rbc;
    o.state_changed = stc;
    o.scan_complete = fin;
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      max_step <= 16'(MS_RESET);
      snap_margin <= 8'(SM_RESET);
      phase <= CTL_IDLE;
      sp_x <= '0; sp_y <= '0; rb_x <= '0; rb_y <= '0;
      npts <= 0; cursor <= 0;
      mismatches <= 0;
      scans_done <= 0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_STEP) max_step = cfg_wdata;
        else snap_margin = cfg_wdata[7:0];
      end
      if (in_valid && in_ready) begin
        want = predict_result(in_data);
        awaited_results.insert(awaited_results.size(), want);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected result: got %p", $time, out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want.scan_complete) scans_done <= scans_done + 1;
          if (out_data !== want) begin
            $display("%0t expected st=%0d state=%0d sp=(%h,%h) rb=(%h,%h) chg=%b%b%b done=%b",
                     $time, want.status, want.scan_state, want.setpoint_x, want.setpoint_y,
                     want.readback_x, want.readback_y, want.setpoint_changed,
                     want.readback_changed, want.state_changed, want.scan_complete);
            $display("%0t actual   st=%0d state=%0d sp=(%h,%h) rb=(%h,%h) chg=%b%b%b done=%b",
                     $time, out_data.status, out_data.scan_state, out_data.setpoint_x,
                     out_data.setpoint_y, out_data.readback_x, out_data.readback_y,
                     out_data.setpoint_changed, out_data.readback_changed,
                     out_data.state_changed, out_data.scan_complete);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> bench/tb_xy_scan_motion_sequencer_top.sv
// tb_xy_scan_motion_sequencer_top: stimulus and verdict for the xy scan motion sequencer
// depends on xsms_pkg, xy_scan_motion_sequencer_top and xsms_scoreboard
`timescale 1ns / 1ps

module tb_xy_scan_motion_sequencer_top;
  import xsms_pkg::*;

  localparam int NUM_ITEMS   = 1850;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  in_item_t    in_data;
  logic        out_valid, out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  int          mismatches, pending, scans_done;
  int          sent;
  int          cycles;
  bit          calm;
  int          next_cfg;

  xy_scan_motion_sequencer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  xsms_scoreboard chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending), .scans_done(scans_done)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready = calm || ($urandom_range(99) >= 35);
  end

  function automatic in_item_t mk(logic [3:0] m, logic [31:0] x, logic [31:0] y,
                                  logic [7:0] rc);
    in_item_t it;
    it.mode = m;
    it.coord_x = x;
    it.coord_y = y;
    it.rewind_count = rc;
    return it;
  endfunction

  function automatic logic [31:0] near_coord();
    return $urandom_range(400000) - 200000;
  endfunction

  task automatic send(input in_item_t it);
    if (!calm && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic cmd(input logic [3:0] m);
    send(mk(m, near_coord(), near_coord(), $urandom_range(255)));
  endtask

  task automatic send_noise();
    send(mk($urandom_range(15), $urandom, $urandom, $urandom_range(255)));
  endtask

  // hold the sender back until every transaction has been answered
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_regs(input logic [15:0] step, input logic [7:0] margin);
    drain();
    cfg_we = 1'b1;
    cfg_index = REG_MAX_STEP;
    cfg_wdata = step;
    @(negedge clk);
    cfg_index = REG_SNAP_MARGIN;
    cfg_wdata = {8'h00, margin};
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_scan();
    int n, steps, r;
    send(mk(MODE_ABORT, 0, 0, 0));
    send(mk(MODE_SET, near_coord(), near_coord(), 0));
    repeat ($urandom_range(3)) cmd(MODE_TICK);
    cmd(MODE_CONFIG);
    n = ($urandom_range(15) == 0) ? $urandom_range(64, 67) : $urandom_range(6);
    repeat (n) cmd(MODE_APPEND);
    cmd(MODE_RUN);
    steps = $urandom_range(5, 40);
    repeat (steps) begin
      r = $urandom_range(99);
      if (r < 75) cmd(MODE_TICK);
      else if (r < 80) cmd(MODE_PAUSE);
      else if (r < 85) cmd(MODE_RESUME);
      else if (r < 90)
        send(mk(MODE_REWIND, 0, 0, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                             : $urandom_range(4)));
      else if (r < 95) send_noise();
      else cmd(MODE_STOP);
    end
    if ($urandom_range(1)) cmd(MODE_STOP);
  endtask

  initial begin
    logic [15:0] steps_tab [6];
    logic [7:0]  margins_tab [6];
    int k;
    steps_tab = '{16'd1, 16'd65535, 16'd30000, 16'd40000, 16'd12000, 16'd52000};
    margins_tab = '{8'd0, 8'd255, 8'd17, 8'd0, 8'd200, 8'd3};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_STEP;
    cfg_wdata = '0;
    cycles = 0;
    sent = 0;
    calm = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every command, reset register values first
    send(mk(MODE_SET, 32'h8000_0000, 32'h7fff_ffff, 0));
    send(mk(MODE_TICK, 0, 0, 0));
    send(mk(MODE_TICK, 0, 0, 0));
    send(mk(MODE_ABORT, 0, 0, 0));
    send(mk(MODE_SET, 32'h7fff_ffff, 32'h8000_0000, 8'h7f));
    send(mk(MODE_PAUSE, 0, 0, 0));
    send(mk(MODE_TICK, 0, 0, 0));
    send(mk(MODE_CONFIG, 0, 0, 0));
    send(mk(MODE_RUN, 0, 0, 0));
    send(mk(MODE_REWIND, 0, 0, 8'd1));
    send(mk(MODE_TICK, 0, 0, 0));
    send(mk(MODE_CONFIG, 0, 0, 0));
    send(mk(MODE_APPEND, 32'hffff_ffff, 32'h0000_0000, 0));
    send(mk(MODE_SET, 0, 0, 0));
    send(mk(MODE_RUN, 0, 0, 0));
    send(mk(MODE_TICK, 0, 0, 0));
    send(mk(MODE_PAUSE, 0, 0, 0));
    send(mk(MODE_TICK, 0, 0, 0));
    send(mk(MODE_REWIND, 0, 0, 8'h80));
    send(mk(MODE_REWIND, 0, 0, 8'h00));
    send(mk(MODE_REWIND, 0, 0, 8'h7f));
    send(mk(MODE_RESUME, 0, 0, 0));
    send(mk(MODE_STOP, 0, 0, 0));
    send(mk(4'hf, 32'hffff_ffff, 32'hffff_ffff, 8'hff));
    send(mk(MODE_ABORT, 0, 0, 0));

    k = 0;
    next_cfg = 0;
    while (sent < NUM_ITEMS) begin
      if (sent >= next_cfg) begin
        set_regs(steps_tab[k % 6], margins_tab[k % 6]);
        k++;
        next_cfg = sent + 300;
      end
      calm = (sent > 900 && sent < 1200);
      if ($urandom_range(99) < 65) run_scan();
      else repeat ($urandom_range(1, 6)) send_noise();
    end
    calm = 0;

    drain();
    $display("%0d transactions sent over %0d register settings, %0d scans ran to completion",
             sent, k, scans_done);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/xsms_pkg.sv
rtl/xsms_ram.sv
rtl/xsms_motion.sv
rtl/xy_scan_motion_sequencer_top.sv
bench/xsms_scoreboard.sv
bench/tb_xy_scan_motion_sequencer_top.sv
